>>> src/daisy_chain_balance_command_receiver_assert.svh
// ============================================================================
// Assertion macros for the daisy-chain balance command receiver
// Shorthand for clocked implication checks with an active-low reset.
// ============================================================================
`ifndef DAISY_CHAIN_BALANCE_COMMAND_RECEIVER_ASSERT_SVH
`define DAISY_CHAIN_BALANCE_COMMAND_RECEIVER_ASSERT_SVH

// same-cycle implication
`define DCBR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcbr same-cycle check failed");

// next-cycle implication
`define DCBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcbr next-cycle check failed");

`endif

>>> src/dcbr_pkg.sv
// ============================================================================
// dcbr_pkg
// Types and constants shared by the balance command receiver modules.
// ============================================================================
`timescale 1ns / 1ps

package dcbr_pkg;

    localparam int BYTES_PER_BOARD = 12;
    localparam int RELAY_W         = 12;
    localparam int RELAY_MAX       = (1 << RELAY_W) - 1;
    localparam int PROD_W          = 8 + $clog2(BYTES_PER_BOARD + 1);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HOP     = 3'd1,
        PH_BOARDS  = 3'd2,
        PH_MASK    = 3'd3,
        PH_RELAY   = 3'd4,
        PH_ADDR    = 3'd5,
        PH_CFGDATA = 3'd6,
        PH_EEDATA  = 3'd7
    } rx_phase_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_MEASURE  = 3'd1,
        EV_SEND     = 3'd2,
        EV_EEREAD   = 3'd3,
        EV_EEWRITE  = 3'd4,
        EV_CFGREAD  = 3'd5,
        EV_CFGWRITE = 3'd6,
        EV_CFGSAVE  = 3'd7
    } event_t;

    typedef enum logic [2:0] {
        CFG_CODE_BALANCE   = 3'd0,
        CFG_CODE_EE_READ   = 3'd1,
        CFG_CODE_EE_WRITE  = 3'd2,
        CFG_CODE_CFG_READ  = 3'd3,
        CFG_CODE_CFG_WRITE = 3'd4,
        CFG_CODE_CFG_SAVE  = 3'd5,
        CFG_CODE_SET_ADDR  = 3'd6,
        CFG_LOAD_OFF_TICKS = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] code_balance_info;
        logic [7:0] code_eeprom_read;
        logic [7:0] code_eeprom_write;
        logic [7:0] code_config_read;
        logic [7:0] code_config_write;
        logic [7:0] code_config_save;
        logic [7:0] code_set_address;
        logic [7:0] load_off_ticks;
    } cfg_regs_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [2:0] event_res;
        logic [7:0] req_address;
        logic [7:0] req_data;
        logic [7:0] load_enable;
        logic       timed_out;
    } result_t;

    typedef struct packed {
        logic out_valid;
        logic skid_valid;
    } buf_status_t;

endpackage

>>> src/dcbr_cfg_regs.sv
// ============================================================================
// dcbr_cfg_regs
// Command code and timeout registers, written through the config port.
// ============================================================================
`timescale 1ns / 1ps

module dcbr_cfg_regs
    import dcbr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic [2:0] wr_index,
    input  logic [7:0] wr_data,
    output cfg_regs_t  cfg
);

    cfg_regs_t cfg_reg;
    cfg_regs_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_index_t'(wr_index))
                CFG_CODE_BALANCE:   cfg_next.code_balance_info = wr_data;
                CFG_CODE_EE_READ:   cfg_next.code_eeprom_read  = wr_data;
                CFG_CODE_EE_WRITE:  cfg_next.code_eeprom_write = wr_data;
                CFG_CODE_CFG_READ:  cfg_next.code_config_read  = wr_data;
                CFG_CODE_CFG_WRITE: cfg_next.code_config_write = wr_data;
                CFG_CODE_CFG_SAVE:  cfg_next.code_config_save  = wr_data;
                CFG_CODE_SET_ADDR:  cfg_next.code_set_address  = wr_data;
                CFG_LOAD_OFF_TICKS: cfg_next.load_off_ticks    = wr_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_balance_info <= 8'd1;
            cfg_reg.code_eeprom_read  <= 8'd2;
            cfg_reg.code_eeprom_write <= 8'd3;
            cfg_reg.code_config_read  <= 8'd4;
            cfg_reg.code_config_write <= 8'd5;
            cfg_reg.code_config_save  <= 8'd6;
            cfg_reg.code_set_address  <= 8'd7;
            cfg_reg.load_off_ticks    <= 8'd50;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/dcbr_core.sv
// ============================================================================
// dcbr_core
// Protocol state machine: decodes one byte or tick per accepted transaction
// and forms its result combinationally.
// ============================================================================
`timescale 1ns / 1ps

module dcbr_core
    import dcbr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  item_t     item,
    input  cfg_regs_t cfg,
    output result_t   res
);

    rx_phase_t          phase_reg, phase_next;
    logic [7:0]         hop_reg, hop_next;
    logic [7:0]         boards_reg, boards_next;
    logic [7:0]         pos_reg, pos_next;
    logic [RELAY_W-1:0] relay_reg, relay_next;
    logic [7:0]         mask_reg, mask_next;
    logic [7:0]         tick_reg, tick_next;
    logic [7:0]         addr_reg, addr_next;

    logic               is_byte;
    logic [7:0]         b;
    logic               m_bal, m_eer, m_eew, m_cfr, m_cfw, m_cfs, m_adr;
    logic [7:0]         pos_inc;
    logic               mask_end;
    logic [PROD_W-1:0]  relay_product;
    logic [RELAY_W-1:0] relay_len;
    logic [RELAY_W-1:0] relay_dec;

    assign is_byte = !item.operation;
    assign b       = item.rx_byte;

    // first match wins in this order
    assign m_bal = (b == cfg.code_balance_info);
    assign m_eer = !m_bal && (b == cfg.code_eeprom_read);
    assign m_eew = !m_bal && !m_eer && (b == cfg.code_eeprom_write);
    assign m_cfr = !m_bal && !m_eer && !m_eew && (b == cfg.code_config_read);
    assign m_cfw = !m_bal && !m_eer && !m_eew && !m_cfr && (b == cfg.code_config_write);
    assign m_cfs = !m_bal && !m_eer && !m_eew && !m_cfr && !m_cfw
                   && (b == cfg.code_config_save);
    assign m_adr = !m_bal && !m_eer && !m_eew && !m_cfr && !m_cfw && !m_cfs
                   && (b == cfg.code_set_address);

    assign pos_inc       = pos_reg + 8'd1;
    assign mask_end      = (boards_reg == pos_inc);
    assign relay_product = PROD_W'(hop_reg) * PROD_W'(BYTES_PER_BOARD);
    assign relay_len     = (32'(relay_product) > 32'(RELAY_MAX)) ?
                           RELAY_W'(RELAY_MAX) : RELAY_W'(relay_product);
    assign relay_dec     = relay_reg - RELAY_W'(relay_reg != '0);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (is_byte)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (m_bal)
                        phase_next = PH_HOP;
                    else if (m_eew)
                        phase_next = PH_EEDATA;
                    else if (m_cfw)
                        phase_next = PH_CFGDATA;
                    else if (m_adr)
                        phase_next = PH_ADDR;
                end
                PH_HOP:    phase_next = PH_BOARDS;
                PH_BOARDS: phase_next = PH_MASK;
                PH_MASK:
                begin
                    if (mask_end)
                        phase_next = (hop_reg == 8'd0) ? PH_IDLE : PH_RELAY;
                end
                PH_RELAY:
                begin
                    if (relay_dec == '0)
                        phase_next = PH_IDLE;
                end
                default:   phase_next = PH_IDLE;
            endcase
        end
    end

    // datapath and result
    always_comb
    begin
        hop_next       = hop_reg;
        boards_next    = boards_reg;
        pos_next       = pos_reg;
        relay_next     = relay_reg;
        mask_next      = mask_reg;
        tick_next      = tick_reg;
        addr_next      = addr_reg;
        res            = '0;
        res.event_res  = EV_NONE;

        if (!is_byte)
        begin
            if (tick_reg == cfg.load_off_ticks)
            begin
                mask_next     = 8'd0;
                res.timed_out = 1'b1;
            end
            else
            begin
                tick_next = tick_reg + 8'd1;
            end
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (m_bal)
                    begin
                        res.tx_valid  = 1'b1;
                        res.tx_byte   = cfg.code_balance_info;
                        res.event_res = EV_MEASURE;
                        tick_next     = 8'd0;
                    end
                    else if (m_eer)
                        res.event_res = EV_EEREAD;
                    else if (m_cfr)
                        res.event_res = EV_CFGREAD;
                    else if (m_cfs)
                        res.event_res = EV_CFGSAVE;
                end
                PH_HOP:
                begin
                    hop_next     = b;
                    res.tx_valid = 1'b1;
                    res.tx_byte  = b + 8'd1;
                end
                PH_BOARDS:
                begin
                    boards_next  = b;
                    pos_next     = 8'd0;
                    res.tx_valid = 1'b1;
                    res.tx_byte  = b;
                end
                PH_MASK:
                begin
                    if (hop_reg == pos_reg)
                    begin
                        mask_next    = b;
                        res.tx_valid = 1'b1;
                        res.tx_byte  = b;
                    end
                    pos_next = pos_inc;
                    if (mask_end)
                    begin
                        if (hop_reg == 8'd0)
                            res.event_res = EV_SEND;
                        else
                        begin
                            relay_next = relay_len;
                            pos_next   = 8'd0;
                        end
                    end
                end
                PH_RELAY:
                begin
                    if (relay_reg != '0)
                    begin
                        relay_next   = relay_dec;
                        res.tx_valid = 1'b1;
                        res.tx_byte  = b;
                    end
                    if (relay_dec == '0)
                        res.event_res = EV_SEND;
                end
                PH_ADDR:    addr_next = b;
                PH_CFGDATA:
                begin
                    res.event_res = EV_CFGWRITE;
                    res.req_data  = b;
                end
                default:
                begin
                    res.event_res = EV_EEWRITE;
                    res.req_data  = b;
                end
            endcase
        end

        res.req_address = addr_next;
        res.load_enable = mask_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            hop_reg    <= '0;
            boards_reg <= '0;
            pos_reg    <= '0;
            relay_reg  <= '0;
            mask_reg   <= '0;
            tick_reg   <= '0;
            addr_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            hop_reg    <= hop_next;
            boards_reg <= boards_next;
            pos_reg    <= pos_next;
            relay_reg  <= relay_next;
            mask_reg   <= mask_next;
            tick_reg   <= tick_next;
            addr_reg   <= addr_next;
        end
    end

endmodule

>>> src/dcbr_out_buf.sv
// ============================================================================
// dcbr_out_buf
// Two-entry result buffer: output register plus skid register, so the
// upstream stall is a register output.
// ============================================================================
`timescale 1ns / 1ps

module dcbr_out_buf
    import dcbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  result_t     push_data,
    output logic        full,
    output logic        out_valid,
    input  logic        out_stall,
    output result_t     out_data,
    output buf_status_t status
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    out_fire;

    assign out_fire = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full              = skid_valid_reg;
    assign out_valid         = out_valid_reg;
    assign out_data          = out_data_reg;
    assign status.out_valid  = out_valid_reg;
    assign status.skid_valid = skid_valid_reg;

endmodule

>>> src/daisy_chain_balance_command_receiver.sv
// ============================================================================
// daisy_chain_balance_command_receiver
// Slave node of a daisy-chained balancer byte protocol.
// ============================================================================
// Takes one received byte or timer tick per clock while item_stall is low
// and returns exactly one result per transaction. The result is presented
// the cycle after it is accepted, unless an earlier result is still held at
// the output; then it waits in the skid entry behind that one. All decoding
// is a single pass of logic from the protocol state registers into a two-entry
// output buffer, so with result_stall low it sustains one transaction per clock;
// input stall rises only when both buffer entries hold results not yet taken.
// Config writes are always ready and take effect on the next clock.
`timescale 1ns / 1ps

`include "daisy_chain_balance_command_receiver_assert.svh"

module daisy_chain_balance_command_receiver
    import dcbr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  item_t      item,
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cfg_regs_t   cfg;
    result_t     step_res;
    logic        accept;
    logic        buf_full;
    buf_status_t buf_status;

    assign cfg_ready  = 1'b1;
    assign item_stall = buf_full;
    assign accept     = item_valid && !buf_full;

    dcbr_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    dcbr_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg),
        .res    (step_res)
    );

    dcbr_out_buf u_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (step_res),
        .full      (buf_full),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_data  (result),
        .status    (buf_status)
    );

    // skid entry only fills behind a held output entry
    `DCBR_ASSERT_IMPLY(a_skid_behind_out, clk, rst_n, buf_status.skid_valid, buf_status.out_valid)
    // an accepted transaction always leaves a valid result at the output next cycle
    `DCBR_ASSERT_NEXT(a_accept_lands, clk, rst_n, accept, result_valid)
    // a timeout result always reports the loads switched off
    `DCBR_ASSERT_IMPLY(a_timeout_clears, clk, rst_n, result_valid && result.timed_out, result.load_enable == 8'd0)
    // no byte data without a downstream send
    `DCBR_ASSERT_IMPLY(a_tx_quiet, clk, rst_n, result_valid && !result.tx_valid, result.tx_byte == 8'd0)

endmodule
